### hw/rtl/tlvrd_pkg.sv
// Package for the record deframer: types, codes and reset constants
package tlvrd_pkg;

  // field and register widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TypeW   = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // register reset values
  localparam logic [7:0]      MarkerByte      = 8'h10;
  localparam int unsigned     LinkBufferBytes = 2000;
  localparam int unsigned     RecordHdrBytes  = 6;
  localparam logic [CfgW-1:0] MarkerRst       = {MarkerByte, MarkerByte};
  localparam logic [CfgW-1:0] MaxLenRst       = CfgW'(LinkBufferBytes - RecordHdrBytes);

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameMarker  = 2'd0,
    CfgMaxPayloadLen = 2'd1
  } cfg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    StPayload   = 2'd0,
    StEmpty     = 2'd1,
    StBadMarker = 2'd2,
    StTooLong   = 2'd3
  } status_e;

  // parser phase: header bytes, payload, halted
  typedef enum logic [3:0] {
    PhMark0   = 4'd0,
    PhMark1   = 4'd1,
    PhType0   = 4'd2,
    PhType1   = 4'd3,
    PhLen0    = 4'd4,
    PhLen1    = 4'd5,
    PhLen2    = 4'd6,
    PhLen3    = 4'd7,
    PhPayload = 4'd8,
    PhHalted  = 4'd9
  } phase_e;

endpackage

### hw/rtl/tlv_record_deframer.sv
// Top level of the record deframer: header parser, payload tagging, result register
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | sink      | in_valid_i/in_ready_o  | in_byte_i
//  out     | source    | out_valid_o/out_ready_i| out_byte_o, record_type_o,
//          |           |                        | record_length_o, last_byte_o, status_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte per cycle while not stalled: each byte is decoded in the cycle it is accepted
// and any result goes into the result register, so the block sustains one item per clock.
// A result waiting in the output register does not block input while out_ready_i is high.
// Input stalls only when the result register is full and the sink is not taking it.
// Reset (async, active low) returns to the first marker byte and reloads the registers;
// after a bad-marker or too-long error the block drops all bytes until the next reset.
module tlv_record_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tlvrd_pkg::ByteW-1:0]  in_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tlvrd_pkg::ByteW-1:0]  out_byte_o,
  output logic [tlvrd_pkg::TypeW-1:0]  record_type_o,
  output logic [tlvrd_pkg::LenW-1:0]   record_length_o,
  output logic                         last_byte_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tlvrd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tlvrd_pkg::CfgW-1:0]   cfg_data_i
);
  import tlvrd_pkg::*;

  // configuration registers
  logic [CfgW-1:0] marker_q, max_len_q;

  // parser state
  phase_e          phase_q, phase_d;
  logic [TypeW-1:0] type_q, type_d;
  logic [LenW-1:0]  len_lo_q, len_lo_d;
  logic             len_hi_q, len_hi_d;
  logic [LenW-1:0]  left_q, left_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic [TypeW-1:0] out_type_q;
  logic [LenW-1:0]  out_len_q;
  logic             out_last_q;
  status_e          out_status_q;

  // result of the current item
  logic             res_emit;
  logic [ByteW-1:0] res_byte;
  logic [TypeW-1:0] res_type;
  logic [LenW-1:0]  res_len;
  logic             res_last;
  status_e          res_status;

  logic             in_fire;
  logic [LenW-1:0]  left_dec;
  logic             too_long;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign left_dec    = left_q - LenW'(1);
  assign too_long    = len_hi_q || (in_byte_i != '0) || (len_lo_q > max_len_q);

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q  <= MarkerRst;
      max_len_q <= MaxLenRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgFrameMarker) begin
        marker_q <= cfg_data_i;
      end else if (cfg_index_i == CfgMaxPayloadLen) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  // next state and result for one byte
  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    len_lo_d   = len_lo_q;
    len_hi_d   = len_hi_q;
    left_d     = left_q;
    res_emit   = 1'b0;
    res_byte   = '0;
    res_type   = type_q;
    res_len    = len_lo_q;
    res_last   = 1'b0;
    res_status = StPayload;
    if (in_fire) begin
      unique case (phase_q)
        PhMark0: begin
          if (in_byte_i != marker_q[15:8]) begin
            phase_d    = PhHalted;
            res_emit   = 1'b1;
            res_type   = '0;
            res_len    = '0;
            res_status = StBadMarker;
          end else begin
            type_d   = '0;
            len_lo_d = '0;
            len_hi_d = 1'b0;
            phase_d  = PhMark1;
          end
        end
        PhMark1: begin
          if (in_byte_i != marker_q[7:0]) begin
            phase_d    = PhHalted;
            res_emit   = 1'b1;
            res_type   = '0;
            res_len    = '0;
            res_status = StBadMarker;
          end else begin
            phase_d = PhType0;
          end
        end
        PhType0: begin
          type_d  = {in_byte_i, 8'h00};
          phase_d = PhType1;
        end
        PhType1: begin
          type_d  = {type_q[15:8], in_byte_i};
          phase_d = PhLen0;
        end
        PhLen0: begin
          len_lo_d = {len_lo_q[15:8], in_byte_i};
          phase_d  = PhLen1;
        end
        PhLen1: begin
          len_lo_d = {in_byte_i, len_lo_q[7:0]};
          phase_d  = PhLen2;
        end
        PhLen2: begin
          // upper length bytes only matter as nonzero
          len_hi_d = (in_byte_i != '0);
          phase_d  = PhLen3;
        end
        PhLen3: begin
          if (too_long) begin
            phase_d    = PhHalted;
            res_emit   = 1'b1;
            res_len    = (len_hi_q || (in_byte_i != '0)) ? '1 : len_lo_q;
            res_status = StTooLong;
          end else if (len_lo_q == '0) begin
            phase_d    = PhMark0;
            res_emit   = 1'b1;
            res_len    = '0;
            res_last   = 1'b1;
            res_status = StEmpty;
          end else begin
            left_d  = len_lo_q;
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          left_d   = left_dec;
          res_emit = 1'b1;
          res_byte = in_byte_i;
          if (left_dec == '0) begin
            res_last = 1'b1;
            phase_d  = PhMark0;
          end
        end
        default: begin
          phase_d = PhHalted;
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMark0;
      type_q   <= '0;
      len_lo_q <= '0;
      len_hi_q <= 1'b0;
      left_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      len_lo_q <= len_lo_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
    end
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded with each new result
  always_ff @(posedge clk_i) begin
    if (res_emit) begin
      out_byte_q   <= res_byte;
      out_type_q   <= res_type;
      out_len_q    <= res_len;
      out_last_q   <= res_last;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign record_type_o   = out_type_q;
  assign record_length_o = out_len_q;
  assign last_byte_o     = out_last_q;
  assign status_o        = out_status_q;

`ifndef SYNTHESIS
  // once halted the parser stays halted
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHalted |=> phase_q == PhHalted)
    else $error("halted parser left halt");

  // an error result always leaves the parser halted
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_emit && (res_status == StBadMarker || res_status == StTooLong)
    |=> phase_q == PhHalted)
    else $error("error result without halt");

  // last flag only on payload or empty-record results
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> status_o == StPayload || status_o == StEmpty)
    else $error("last flag on error result");

  // payload results only come while a record body is being counted
  a_payload_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_emit && res_status == StPayload |-> phase_q == PhPayload && left_q != '0)
    else $error("payload byte outside record body");
`endif

endmodule

### verif/tlv_record_deframer_tb.sv
`timescale 1ns / 100ps
// Testbench for the record deframer: streams framed records and checks every tagged result
module tlv_record_deframer_tb;
  import tlvrd_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  // payload fill patterns
  localparam int FillRand = 0;
  localparam int FillZero = 1;
  localparam int FillOnes = 2;

  // final error choices
  localparam int EndBadMark0 = 0;
  localparam int EndBadMark1 = 1;
  localparam int EndTooLong  = 2;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [TypeW-1:0] rtype;
    logic [LenW-1:0]  rlen;
    logic             last;
    status_e          status;
  } tlv_result_t;

  // tracks the parser state and the tagged results still owed by the block
  class record_tracker;
    logic [CfgW-1:0] marker;
    logic [CfgW-1:0] max_len;
    phase_e          ph;
    logic [15:0]     type_q;
    logic [31:0]     len_acc;
    logic [15:0]     left;
    tlv_result_t     results_due[$];
    int              mismatches;
    int              n_matched;

    function new();
      marker     = MarkerRst;
      max_len    = MaxLenRst;
      ph         = PhMark0;
      type_q     = '0;
      len_acc    = '0;
      left       = '0;
      mismatches = 0;
      n_matched  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == CfgFrameMarker) begin
        marker = data;
      end else if (idx == CfgMaxPayloadLen) begin
        max_len = data;
      end
    endfunction

    function void post(logic [7:0] data, logic [15:0] rtype, logic [15:0] rlen,
                       logic last, status_e status);
      tlv_result_t r;
      r.data   = data;
      r.rtype  = rtype;
      r.rlen   = rlen;
      r.last   = last;
      r.status = status;
      results_due.push_back(r);
    endfunction

    // advance the parser by one accepted byte
    function void take_byte(logic [7:0] b);
      logic [7:0]  want;
      logic [31:0] len;
      case (ph)
        PhMark0, PhMark1: begin
          want = (ph == PhMark0) ? marker[15:8] : marker[7:0];
          if (b != want) begin
            ph = PhHalted;
            post(8'h00, 16'h0000, 16'h0000, 1'b0, StBadMarker);
          end else if (ph == PhMark0) begin
            type_q  = '0;
            len_acc = '0;
            ph      = PhMark1;
          end else begin
            ph = PhType0;
          end
        end
        PhType0: begin
          type_q = {b, 8'h00};
          ph     = PhType1;
        end
        PhType1: begin
          type_q[7:0] = b;
          ph          = PhLen0;
        end
        PhLen0: begin
          len_acc = len_acc | 32'(b);
          ph      = PhLen1;
        end
        PhLen1: begin
          len_acc = len_acc | (32'(b) << 8);
          ph      = PhLen2;
        end
        PhLen2: begin
          len_acc = len_acc | (32'(b) << 16);
          ph      = PhLen3;
        end
        PhLen3: begin
          len     = len_acc | (32'(b) << 24);
          len_acc = len;
          if (len > {16'h0000, max_len}) begin
            ph = PhHalted;
            post(8'h00, type_q, (len > 32'h0000_FFFF) ? 16'hFFFF : len[15:0], 1'b0,
                 StTooLong);
          end else if (len == 0) begin
            ph = PhMark0;
            post(8'h00, type_q, 16'h0000, 1'b1, StEmpty);
          end else begin
            left = len[15:0];
            ph   = PhPayload;
          end
        end
        PhPayload: begin
          left = left - 16'd1;
          if (left == 0) begin
            ph = PhMark0;
            post(b, type_q, len_acc[15:0], 1'b1, StPayload);
          end else begin
            post(b, type_q, len_acc[15:0], 1'b0, StPayload);
          end
        end
        default: ph = PhHalted;
      endcase
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // compare one accepted result against the oldest one owed
    function void match_result(logic [7:0] data, logic [15:0] rtype, logic [15:0] rlen,
                               logic last, logic [1:0] status);
      tlv_result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual byte %h status %0d",
                 $time, data, status);
        return;
      end
      want = results_due.pop_front();
      n_matched++;
      field_check("out_byte", 32'(want.data), 32'(data));
      field_check("record_type", 32'(want.rtype), 32'(rtype));
      field_check("record_length", 32'(want.rlen), 32'(rlen));
      field_check("last_byte", 32'(want.last), 32'(last));
      field_check("status", 32'(want.status), 32'(status));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ByteW-1:0]    in_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ByteW-1:0]    out_byte_o;
  logic [TypeW-1:0]    record_type_o;
  logic [LenW-1:0]     record_length_o;
  logic                last_byte_o;
  logic [1:0]          status_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  record_tracker tracker;
  bit            quiet;
  int            idle_cycles;
  int            n_bytes;
  int            n_records;
  int            n_writes;

  tlv_record_deframer dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .record_type_o,
    .record_length_o,
    .last_byte_o,
    .status_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // payload length within the current limit, mostly short
  function automatic logic [31:0] pick_len(logic [15:0] lim);
    int r;
    int cap;
    r   = $urandom_range(0, 99);
    cap = (lim < 24) ? int'(lim) : 24;
    if (r < 10 || cap == 0) return 32'd0;
    if (r < 20) return 32'(cap);
    return 32'($urandom_range(1, cap));
  endfunction

  // result check and progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.match_result(out_byte_o, record_type_o, record_length_o, last_byte_o,
                             status_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result sink with random stalls
  initial begin
    int run;
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      out_ready_i = 1'b1;
      run = $urandom_range(1, 40);
      repeat (run) @(negedge clk_i);
      stall = quiet ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // one byte on the input channel, called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_byte(b);
    n_bytes++;
    @(negedge clk_i);
  endtask

  // header plus payload; payload only when the length is within the limit
  task automatic send_record(input logic [15:0] rtype, input logic [31:0] rlen,
                             input int fill);
    logic [7:0] b;
    int         i;
    send_byte(tracker.marker[15:8]);
    send_byte(tracker.marker[7:0]);
    send_byte(rtype[15:8]);
    send_byte(rtype[7:0]);
    for (i = 0; i < 4; i++) send_byte(rlen[8*i +: 8]);
    if (rlen <= {16'h0000, tracker.max_len}) begin
      for (i = 0; i < int'(rlen[15:0]); i++) begin
        case (fill)
          FillZero: b = 8'h00;
          FillOnes: b = 8'hFF;
          default:  b = 8'($urandom);
        endcase
        send_byte(b);
      end
    end
    n_records++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // drain all owed results, then let the result register settle
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (tracker.results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // main sequence
  initial begin
    int          p;
    int          phase_end;
    int          choice;
    logic [15:0] mark;
    logic [15:0] lim;
    logic [31:0] bad_len;
    string       end_name;
    tracker     = new();
    quiet       = 1'b0;
    idle_cycles = 0;
    n_bytes     = 0;
    n_records   = 0;
    n_writes    = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgFrameMarker;
    cfg_data_i  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty record, one-byte record, two-byte record at reset settings
    send_record(16'hFFFF, 32'd0, FillRand);
    send_record(16'h0000, 32'd1, FillZero);
    send_record(16'h8001, 32'd2, FillOnes);

    // random records over several register settings
    for (p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin mark = MarkerRst; lim = MaxLenRst; end
        1: begin mark = 16'h0000; lim = 16'h0000; end
        2: begin mark = 16'hFFFF; lim = 16'hFFFF; end
        3: begin mark = 16'($urandom); lim = 16'($urandom_range(1, 8)); end
        4: begin mark = 16'($urandom); lim = 16'h0001; end
        5: begin mark = 16'($urandom); lim = 16'($urandom); end
        6: begin mark = 16'($urandom); lim = 16'($urandom_range(9, 40)); end
        default: begin mark = 16'hFF00; lim = 16'($urandom_range(2, 20)); end
      endcase
      write_reg(CfgFrameMarker, mark);
      write_reg(CfgMaxPayloadLen, lim);
      if (p % 3 == 1) begin
        write_reg($urandom_range(0, 1) ? CfgSpare2 : CfgSpare3, 16'($urandom));
      end
      quiet = (p == 5);
      phase_end = n_bytes + 120;
      while (n_bytes < phase_end) begin
        send_record(16'($urandom), pick_len(lim), FillRand);
      end
    end

    // close with one fatal framing error, then bytes the halted block drops
    wait_idle();
    quiet  = 1'b0;
    choice = $urandom_range(EndBadMark0, EndTooLong);
    case (choice)
      EndBadMark0: begin
        end_name = "first-marker-byte";
        send_byte(tracker.marker[15:8] ^ (8'h01 << $urandom_range(0, 7)));
      end
      EndBadMark1: begin
        end_name = "second-marker-byte";
        send_byte(tracker.marker[15:8]);
        send_byte(tracker.marker[7:0] ^ (8'h01 << $urandom_range(0, 7)));
      end
      default: begin
        end_name = "too-long";
        write_reg(CfgMaxPayloadLen, 16'($urandom_range(0, 300)));
        bad_len = $urandom_range(0, 1) ? ({16'h0000, tracker.max_len} + 32'd1)
                                       : ($urandom | 32'h0001_0000);
        send_record(16'($urandom), bad_len, FillRand);
      end
    endcase
    repeat (6) send_byte(8'($urandom));
    in_valid_i = 1'b0;

    while (tracker.results_due.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes in %0d records, checked %0d results, %0d register writes",
             n_bytes, n_records, tracker.n_matched, n_writes);
    $display("run ended on a %s error followed by dropped bytes", end_name);
    if (tracker.mismatches == 0 && tracker.results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tlvrd_pkg.sv
hw/rtl/tlv_record_deframer.sv
verif/tlv_record_deframer_tb.sv
